/* sv/mbp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared widths and constants for the msb-first bit packer.
// ----------------------------------------------------------------------------
package mbp_pkg;

    localparam int MAX_FIELD_BITS_DEF = 32;
    localparam int QUEUE_DEPTH        = 2;

    localparam int COUNT_W  = 6;
    localparam int VALUE_W  = 32;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 16;
    localparam int PART_W   = 7;
    localparam int FILL_W   = 3;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 24;

    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hff;

endpackage

/* sv/msb_first_bit_packer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Appends fields of 0 to 32 bits msb first to a byte stream and emits each
// completed byte with its running stream index.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   s_tdata: bit_count, field_bits
//  m_*      out  m_tvalid/m_tready   m_tdata: out_byte, byte_index; m_tlast
//
//  a field is accepted whenever the queue has room; its bytes leave one per
//  cycle while m_tready is high, through the one-byte output register
//  a field that completes no byte only updates the pending bits
//  a two-entry queue parts the front from the output shifter, so input
//  keeps flowing while the output stalls; s_tready drops when it is full
//  reset clears pending bits, fill count, byte index and the queue
// ----------------------------------------------------------------------------
module msb_first_bit_packer #(
    parameter int MAX_FIELD_BITS = mbp_pkg::MAX_FIELD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // bit_count[5:0], field_bits[37:6], zero pad[39:38]
    input  logic [mbp_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // out_byte[7:0], byte_index[23:8]
    output logic [mbp_pkg::M_DATA_W-1:0] m_tdata,
    output logic                         m_tlast
);
    import mbp_pkg::*;

    localparam int W      = MAX_FIELD_BITS + PART_W;
    localparam int MAXB   = W / BYTE_W;
    localparam int DATA_W = MAXB * BYTE_W;
    localparam int CNT_W  = $clog2(MAXB + 1);

    logic              push;
    logic              queue_full;
    logic              not_empty;
    logic              pop;
    logic [DATA_W-1:0] push_data, pop_data;
    logic [CNT_W-1:0]  push_count, pop_count;
    logic [BYTE_W-1:0] out_byte;
    logic [INDEX_W-1:0] byte_index;

    mbp_front #(
        .MAX_FIELD_BITS(MAX_FIELD_BITS),
        .DATA_W        (DATA_W),
        .CNT_W         (CNT_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .bit_count (s_tdata[COUNT_W-1:0]),
        .field_bits(s_tdata[COUNT_W +: VALUE_W]),
        .push      (push),
        .queue_full(queue_full),
        .push_data (push_data),
        .push_count(push_count)
    );

    mbp_queue #(
        .DATA_W(DATA_W),
        .CNT_W (CNT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .push_count(push_count),
        .full      (queue_full),
        .not_empty (not_empty),
        .pop       (pop),
        .pop_data  (pop_data),
        .pop_count (pop_count)
    );

    mbp_back #(
        .DATA_W(DATA_W),
        .CNT_W (CNT_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .pop       (pop),
        .pop_data  (pop_data),
        .pop_count (pop_count),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (out_byte),
        .byte_index(byte_index),
        .last      (m_tlast)
    );

    assign m_tdata = {byte_index, out_byte};

endmodule

/* sv/mbp_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_front
// Merges each field with the pending bits, counts the bytes it completes and
// queues them left aligned; keeps the unfinished byte and its fill count.
// ----------------------------------------------------------------------------
module mbp_front #(
    parameter int MAX_FIELD_BITS = mbp_pkg::MAX_FIELD_BITS_DEF,
    parameter int DATA_W         = 32,
    parameter int CNT_W          = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mbp_pkg::COUNT_W-1:0] bit_count,
    input  logic [mbp_pkg::VALUE_W-1:0] field_bits,
    output logic                        push,
    input  logic                        queue_full,
    output logic [DATA_W-1:0]           push_data,
    output logic [CNT_W-1:0]            push_count
);
    import mbp_pkg::*;

    localparam int W  = MAX_FIELD_BITS + PART_W;
    localparam int NW = $clog2(MAX_FIELD_BITS + 1);
    localparam int TW = $clog2(W + 1);

    logic [PART_W-1:0] partial_reg, partial_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic [NW-1:0] n;
    logic [W-1:0]  vext;
    logic [W-1:0]  mask;
    logic [W-1:0]  comb;
    logic [W-1:0]  aligned;
    logic [TW-1:0] total;
    logic [TW-1:0] shamt;
    logic          accept;

    always_comb
    begin
        if (32'(bit_count) > MAX_FIELD_BITS)
            n = NW'(MAX_FIELD_BITS);
        else
            n = NW'(bit_count);
        vext         = W'(field_bits);
        mask         = ~({W{1'b1}} << n);
        comb         = (W'(partial_reg) << n) | (vext & mask);
        total        = TW'(fill_reg) + TW'(n);
        shamt        = TW'(W) - total;
        aligned      = comb << shamt;
        fill_next    = total[FILL_W-1:0];
        partial_next = comb[PART_W-1:0] & ~({PART_W{1'b1}} << fill_next);
    end

    assign in_ready   = !queue_full;
    assign accept     = in_valid && in_ready;
    assign push_count = CNT_W'(total >> FILL_W);
    assign push_data  = aligned[W-1 -: DATA_W];
    assign push       = accept && (push_count != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            fill_reg    <= '0;
        end
        else if (accept)
        begin
            partial_reg <= partial_next;
            fill_reg    <= fill_next;
        end
    end

endmodule

/* sv/mbp_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_queue
// Short register queue of byte groups between the front and back parts.
// ----------------------------------------------------------------------------
module mbp_queue #(
    parameter int DATA_W = 32,
    parameter int CNT_W  = 3,
    parameter int DEPTH  = mbp_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic [CNT_W-1:0]  push_count,
    output logic              full,
    output logic              not_empty,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic [CNT_W-1:0]  pop_count
);
    import mbp_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] data_mem_reg [DEPTH];
    logic [CNT_W-1:0]  cnt_mem_reg  [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [OW-1:0]     occ_reg, occ_next;

    assign full      = (occ_reg == OW'(DEPTH));
    assign not_empty = (occ_reg != '0);
    assign pop_data  = data_mem_reg[rd_ptr_reg];
    assign pop_count = cnt_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        occ_next    = occ_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            occ_next = occ_reg + 1'b1;
        else if (pop && !push)
            occ_next = occ_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            occ_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_mem_reg[wr_ptr_reg] <= push_data;
            cnt_mem_reg[wr_ptr_reg]  <= push_count;
        end
    end

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OW'(DEPTH))
        else $error("queue occupancy above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_occ_grow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> occ_reg == $past(occ_reg) + 1'b1)
        else $error("occupancy did not grow on push");
`endif

endmodule

/* sv/mbp_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbp_back
// Shifts queued byte groups out one byte per cycle while out_ready is high,
// with the running index, marking the final byte of each group.
// ----------------------------------------------------------------------------
module mbp_back #(
    parameter int DATA_W = 32,
    parameter int CNT_W  = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        not_empty,
    output logic                        pop,
    input  logic [DATA_W-1:0]           pop_data,
    input  logic [CNT_W-1:0]            pop_count,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mbp_pkg::BYTE_W-1:0]  out_byte,
    output logic [mbp_pkg::INDEX_W-1:0] byte_index,
    output logic                        last
);
    import mbp_pkg::*;

    logic [DATA_W-1:0]  work_data_reg, work_data_next;
    logic [CNT_W-1:0]   work_cnt_reg, work_cnt_next;
    logic [INDEX_W-1:0] pos_reg, pos_next;
    logic               m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]  m_byte_reg, m_byte_next;
    logic [INDEX_W-1:0] m_index_reg, m_index_next;
    logic               m_last_reg, m_last_next;
    logic               out_free;
    logic               emit;

    assign out_free = !m_valid_reg || out_ready;
    assign emit     = out_free && (work_cnt_reg != '0);

    always_comb
    begin
        work_data_next = work_data_reg;
        work_cnt_next  = work_cnt_reg;
        pos_next       = pos_reg;
        m_valid_next   = m_valid_reg;
        m_byte_next    = m_byte_reg;
        m_index_next   = m_index_reg;
        m_last_next    = m_last_reg;
        pop            = 1'b0;
        if (out_free)
            m_valid_next = 1'b0;
        if (emit)
        begin
            m_valid_next   = 1'b1;
            m_byte_next    = work_data_reg[DATA_W-1 -: BYTE_W] & BYTE_MASK;
            m_index_next   = pos_reg;
            m_last_next    = (work_cnt_reg == CNT_W'(1));
            pos_next       = pos_reg + 1'b1;
            work_data_next = work_data_reg << BYTE_W;
            work_cnt_next  = work_cnt_reg - 1'b1;
        end
        if (not_empty && ((work_cnt_reg == '0) || (emit && work_cnt_reg == CNT_W'(1))))
        begin
            pop            = 1'b1;
            work_data_next = pop_data;
            work_cnt_next  = pop_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_cnt_reg <= '0;
            pos_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            work_cnt_reg <= work_cnt_next;
            pos_reg      <= pos_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_data_reg <= work_data_next;
        m_byte_reg    <= m_byte_next;
        m_index_reg   <= m_index_next;
        m_last_reg    <= m_last_next;
    end

    assign out_valid  = m_valid_reg;
    assign out_byte   = m_byte_reg;
    assign byte_index = m_index_reg;
    assign last       = m_last_reg;

`ifndef ASSERT_OFF
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> m_valid_reg)
        else $error("pending byte not presented");

    a_index_track: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> pos_reg == m_index_reg + 1'b1)
        else $error("byte index out of step with position");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> work_cnt_reg != '0)
        else $error("queue pop loaded an empty group");
`endif

endmodule
